// ===== hdl/hhoc_pkg.sv =====
// Package for the heading hold block: item and result words, register codes,
// CORDIC vector type and the arctangent table. No dependencies.
package hhoc_pkg;

	localparam int VW = 56;  // CORDIC x/y width (inputs pre-scaled by 2^20)
	localparam int AW = 32;  // angle width, Q3.28 radians
	localparam int PRE_SHIFT = 20;

	localparam logic signed [AW-1:0] ANG_PI      = 32'sd843314857;
	localparam logic signed [AW-1:0] ANG_HALF_PI = 32'sd421657428;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_CENTER_X = 3'd1,
		REG_CENTER_Y = 3'd2,
		REG_GAIN     = 3'd3,
		REG_MAX_RATE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] cmd_yaw_rate;
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic               pose_valid;
	} item_t;

	typedef struct packed {
		logic signed [15:0] yaw_rate_out;
		logic               steered;
	} result_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [AW-1:0] z;
	} cordic_vec_t;

	// side information that travels alongside the CORDIC pipeline
	typedef struct packed {
		logic               steer;
		logic signed [15:0] cmd;
		logic               yaw_zero;
		logic               brg_zero;
	} side_t;

	// arctangent of 2^-i, Q3.28
	function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
		logic signed [AW-1:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

	// move a left half-plane vector into the right half-plane
	function automatic cordic_vec_t pre_rotate(input logic signed [VW-1:0] x,
			input logic signed [VW-1:0] y);
		cordic_vec_t v;
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				v.x = y;
				v.y = -x;
				v.z = ANG_HALF_PI;
			end else begin
				v.x = -y;
				v.y = x;
				v.z = -ANG_HALF_PI;
			end
		end
		return v;
	endfunction

endpackage

// ===== hdl/hhoc_cordic_stage.sv =====
// One registered vectoring CORDIC micro-rotation.
// Depends on hhoc_pkg.
module hhoc_cordic_stage import hhoc_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  cordic_vec_t vin,
	output cordic_vec_t vout_s1
);

	localparam logic signed [AW-1:0] ATAN = atan_lut(5'(STEP));

	logic signed [VW-1:0] xs, ys;

	assign xs = vin.x >>> STEP;
	assign ys = vin.y >>> STEP;

	// rotate towards y = 0
	always_ff @(posedge clk) begin
		if (vin.y > 0) begin
			vout_s1.x <= vin.x + ys;
			vout_s1.y <= vin.y - xs;
			vout_s1.z <= vin.z + ATAN;
		end else begin
			vout_s1.x <= vin.x - ys;
			vout_s1.y <= vin.y + xs;
			vout_s1.z <= vin.z - ATAN;
		end
	end

endmodule

// ===== hdl/hhoc_prep.sv =====
// Front end: quaternion products, yaw vector, gimbal test, bearing vector,
// pre-scale and half-plane pre-rotation. Three stages. Depends on hhoc_pkg.
module hhoc_prep import hhoc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  item_t              item,
	input  logic               enable,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	output logic               vld_s3,
	output side_t              side_s3,
	output cordic_vec_t        yaw_s3,
	output cordic_vec_t        brg_s3
);

	logic               vld_s1, vld_s2;
	logic               steer_s1;
	logic signed [15:0] cmd_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, wz_s1, xz_s1, wy_s1;
	logic signed [32:0] dx_s1, dy_s1;
	side_t              side_s2;
	logic signed [33:0] yx_s2, yy2_s2;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [33:0] d_sum, s_val, s_abs, ya, xa;

	// stage 1: products and position difference
	always_ff @(posedge clk) begin
		xx_s1    <= item.quat_x * item.quat_x;
		yy_s1    <= item.quat_y * item.quat_y;
		zz_s1    <= item.quat_z * item.quat_z;
		ww_s1    <= item.quat_w * item.quat_w;
		xy_s1    <= item.quat_x * item.quat_y;
		wz_s1    <= item.quat_w * item.quat_z;
		xz_s1    <= item.quat_x * item.quat_z;
		wy_s1    <= item.quat_w * item.quat_y;
		dx_s1    <= 33'(center_x) - 33'(item.robot_x);
		dy_s1    <= 33'(center_y) - 33'(item.robot_y);
		cmd_s1   <= item.cmd_yaw_rate;
		steer_s1 <= enable & item.pose_valid;
	end

	// stage 2: sums and gimbal-lock test
	always_comb begin
		d_sum = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
		s_val = (34'(xz_s1) - 34'(wy_s1)) <<< 1;
		s_abs = (s_val < 0) ? -s_val : s_val;
		ya    = (34'(xy_s1) + 34'(wz_s1)) <<< 1;
		xa    = 34'(xx_s1) + 34'(ww_s1) - 34'(yy_s1) - 34'(zz_s1);
	end

	always_ff @(posedge clk) begin
		yx_s2            <= xa;
		yy2_s2           <= ya;
		dx_s2            <= dx_s1;
		dy_s2            <= dy_s1;
		side_s2.steer    <= steer_s1;
		side_s2.cmd      <= cmd_s1;
		side_s2.yaw_zero <= (s_abs >= d_sum) || (xa == 0 && ya == 0);
		side_s2.brg_zero <= (dx_s1 == 0) && (dy_s1 == 0);
	end

	// stage 3: pre-scale and pre-rotate both vectors
	always_ff @(posedge clk) begin
		yaw_s3  <= pre_rotate(VW'(yx_s2) <<< PRE_SHIFT, VW'(yy2_s2) <<< PRE_SHIFT);
		brg_s3  <= pre_rotate(VW'(dx_s2) <<< PRE_SHIFT, VW'(dy_s2) <<< PRE_SHIFT);
		side_s3 <= side_s2;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

endmodule

// ===== hdl/heading_hold_to_orbit_center.sv =====
// Heading hold toward an orbit center: config registers, two CORDIC pipelines,
// error wrap, gain multiply, round and clamp. Depends on hhoc_pkg,
// hhoc_prep and hhoc_cordic_stage.
//
//  channel   handshake          payload            notes
//  input     start & !busy      item   (item_t)    one word per cycle, busy stays low
//  result    done (1 cycle)     result (result_t)  one word per input word
//  config    cfg_we             cfg_index/cfg_data no wait, no read-back
//
// The pipeline has three front-end stages, one stage per CORDIC
// micro-rotation, then wrap, multiply and round/clamp stages.
// One word can enter every cycle, and one result leaves for each word.
// Reset clears the valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module heading_hold_to_orbit_center import hhoc_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int LAT = CORDIC_STEPS + 6;

	logic               enable_q;
	logic signed [31:0] center_x_q, center_y_q;
	logic [14:0]        gain_q, max_rate_q;

	logic        vld_c   [0:CORDIC_STEPS];
	side_t       side_c  [0:CORDIC_STEPS];
	cordic_vec_t yaw_c   [0:CORDIC_STEPS];
	cordic_vec_t brg_c   [0:CORDIC_STEPS];

	logic               vld_e1, vld_e2;
	side_t              side_e1, side_e2;
	logic signed [32:0] err_e1;
	logic signed [48:0] prod_e2;
	logic signed [32:0] err_raw, err_w1, err_w2;
	logic signed [31:0] yaw_ang, brg_ang;
	logic signed [48:0] rnd;
	logic signed [20:0] rate, max_s;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			center_x_q <= '0;
			center_y_q <= '0;
			gain_q     <= 15'd6144;
			max_rate_q <= 15'd2048;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_GAIN:     gain_q     <= cfg_data[14:0];
				REG_MAX_RATE: max_rate_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	hhoc_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (start & ~busy),
		.item     (item),
		.enable   (enable_q),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.vld_s3   (vld_c[0]),
		.side_s3  (side_c[0]),
		.yaw_s3   (yaw_c[0]),
		.brg_s3   (brg_c[0])
	);

	// CORDIC pipelines, one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		hhoc_cordic_stage #(.STEP(i)) u_yaw (
			.clk     (clk),
			.vin     (yaw_c[i]),
			.vout_s1 (yaw_c[i+1])
		);
		hhoc_cordic_stage #(.STEP(i)) u_brg (
			.clk     (clk),
			.vin     (brg_c[i]),
			.vout_s1 (brg_c[i+1])
		);
		always_ff @(posedge clk) begin
			side_c[i+1] <= side_c[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[i+1] <= 1'b0;
			end else begin
				vld_c[i+1] <= vld_c[i];
			end
		end
	end

	// heading error, wrapped to (-pi, pi]
	always_comb begin
		yaw_ang = side_c[CORDIC_STEPS].yaw_zero ? '0 : yaw_c[CORDIC_STEPS].z;
		brg_ang = side_c[CORDIC_STEPS].brg_zero ? '0 : brg_c[CORDIC_STEPS].z;
		err_raw = 33'(brg_ang) - 33'(yaw_ang);
		err_w1  = (err_raw > 33'(ANG_PI)) ? err_raw - (33'(ANG_PI) <<< 1) : err_raw;
		err_w2  = (err_w1 <= -33'(ANG_PI)) ? err_w1 + (33'(ANG_PI) <<< 1) : err_w1;
	end

	always_ff @(posedge clk) begin
		err_e1  <= err_w2;
		side_e1 <= side_c[CORDIC_STEPS];
		prod_e2 <= $signed({34'd0, gain_q}) * 49'(err_e1);
		side_e2 <= side_e1;
	end

	// round, clamp and choose passthrough
	always_comb begin
		rnd   = prod_e2 + 49'sd134217728;
		rate  = 21'(rnd >>> 28);
		max_s = 21'($signed({1'b0, max_rate_q}));
		if (rate > max_s) begin
			rate = max_s;
		end
		if (rate < -max_s) begin
			rate = -max_s;
		end
	end

	always_ff @(posedge clk) begin
		result.steered      <= side_e2.steer;
		result.yaw_rate_out <= side_e2.steer ? rate[15:0] : side_e2.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_e1 <= 1'b0;
			vld_e2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_e1 <= vld_c[CORDIC_STEPS];
			vld_e2 <= vld_e1;
			done   <= vld_e2;
		end
	end

	// every result traces back to an accepted word
	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without an accepted word");

	// passthrough keeps the commanded rate
	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.steered |-> result.yaw_rate_out == $past(item.cmd_yaw_rate, LAT))
		else $error("passthrough rate altered");

	// steered rate stays inside the limit
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.steered |->
			$signed(result.yaw_rate_out) <= $signed({1'b0, max_rate_q}) &&
			$signed(result.yaw_rate_out) >= -$signed({1'b0, max_rate_q}))
		else $error("steered rate beyond limit");

endmodule

// ===== tb/heading_hold_to_orbit_center_test.sv =====
// Self-checking bench for heading_hold_to_orbit_center: a directed table, then
// random words over several register settings, checked against a local model.
// Depends on hhoc_pkg and the block's RTL.
module heading_hold_to_orbit_center_test;
	import hhoc_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int LATENCY = CORDIC_STEPS + 6;
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int RAND_PHASES = 8;
	localparam int WORDS_PER_PHASE = 140;

	// arctangent of 2^-i in Q3.28
	localparam longint ATAN_Q28 [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32};

	typedef struct {
		int      phase;
		item_t   word;
		bit      fixed;
		result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// local copy of the registers
	bit     m_enable;
	longint m_cx, m_cy, m_gain, m_max;

	result_t   rate_q[$];
	stim_row_t rows[$];
	int        errors;
	bit        cur_fixed;
	result_t   cur_want;
	int        burst_left;

	heading_hold_to_orbit_center #(.CORDIC_STEPS(CORDIC_STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("heading_hold_to_orbit_center regression: fail");
		$finish;
	end

	// vectoring CORDIC angle of (x, y), Q3.28
	function automatic longint bearing_of(longint yv, longint xv);
		longint xa, ya, za, xs, ys, t;
		za = 0;
		if (xv == 0 && yv == 0)
			return 0;
		xa = xv <<< PRE_SHIFT;
		ya = yv <<< PRE_SHIFT;
		if (xa < 0) begin
			t = xa;
			if (ya >= 0) begin
				xa = ya; ya = -t; za = ANG_HALF_PI;
			end else begin
				xa = -ya; ya = t; za = -longint'(ANG_HALF_PI);
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = xa >>> i;
			ys = ya >>> i;
			if (ya > 0) begin
				xa += ys; ya -= xs; za += ATAN_Q28[i];
			end else begin
				xa -= ys; ya += xs; za -= ATAN_Q28[i];
			end
		end
		return za;
	endfunction

	// expected yaw rate for one word under the current registers
	function automatic result_t steer_rate(item_t w);
		result_t r;
		longint qx, qy, qz, qw, d, s, yaw, brg, err, rate, pi;
		pi = ANG_PI;
		if (!m_enable || !w.pose_valid) begin
			r.yaw_rate_out = w.cmd_yaw_rate;
			r.steered = 1'b0;
			return r;
		end
		qx = w.quat_x; qy = w.quat_y; qz = w.quat_z; qw = w.quat_w;
		d = qx*qx + qy*qy + qz*qz + qw*qw;
		s = 2 * (qx*qz - qw*qy);
		if (s < 0)
			s = -s;
		// pitch at +/-90 degrees (and the zero quaternion) gives yaw 0
		yaw = (s >= d) ? 0 : bearing_of(2 * (qx*qy + qw*qz), qx*qx + qw*qw - qy*qy - qz*qz);
		brg = bearing_of(m_cy - longint'(w.robot_y), m_cx - longint'(w.robot_x));
		err = brg - yaw;
		if (err > pi)
			err -= 2 * pi;
		if (err <= -pi)
			err += 2 * pi;
		rate = (m_gain * err + (longint'(1) <<< 27)) >>> 28;
		if (rate > m_max)
			rate = m_max;
		if (rate < -m_max)
			rate = -m_max;
		r.yaw_rate_out = 16'(rate);
		r.steered = 1'b1;
		return r;
	endfunction

	// check delivered words, then log accepted ones
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (rate_q.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				errors++;
			end else begin
				e = rate_q[0];
				rate_q.delete(0);
				if (result.yaw_rate_out !== e.yaw_rate_out) begin
					$display("%0t: yaw_rate_out expected %0d got %0d", $time,
						e.yaw_rate_out, result.yaw_rate_out);
					errors++;
				end
				if (result.steered !== e.steered) begin
					$display("%0t: steered expected %0b got %0b", $time,
						e.steered, result.steered);
					errors++;
				end
			end
		end
		if (arst_n && start && !busy)
			rate_q.insert(rate_q.size(), cur_fixed ? cur_want : steer_rate(item));
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ENABLE:   m_enable = val[0];
			REG_CENTER_X: m_cx = longint'(signed'(val));
			REG_CENTER_Y: m_cy = longint'(signed'(val));
			REG_GAIN:     m_gain = val[14:0];
			REG_MAX_RATE: m_max = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(bit en, int cx, int cy, int gain, int mx);
		write_reg(REG_ENABLE, 32'(en));
		write_reg(REG_CENTER_X, 32'(cx));
		write_reg(REG_CENTER_Y, 32'(cy));
		write_reg(REG_GAIN, 32'(gain));
		write_reg(REG_MAX_RATE, 32'(mx));
	endtask

	// idle the input and let the pipeline empty
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (rate_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one word, sent in bursts with random gaps
	task automatic send(item_t w, bit fixed, result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		cur_fixed = fixed;
		cur_want = want;
		do @(posedge clk); while (busy);
	endtask

	function automatic item_t make_word(int cmd, int rx, int ry, int qx, int qy,
			int qz, int qw, bit pv);
		item_t w;
		w.cmd_yaw_rate = 16'(cmd);
		w.robot_x = 32'(rx);
		w.robot_y = 32'(ry);
		w.quat_x = 16'(qx);
		w.quat_y = 16'(qy);
		w.quat_z = 16'(qz);
		w.quat_w = 16'(qw);
		w.pose_valid = pv;
		return w;
	endfunction

	function automatic void add_row(int ph, item_t w, bit fixed, int want_rate, bit want_st);
		stim_row_t r;
		r.phase = ph;
		r.word = w;
		r.fixed = fixed;
		r.want.yaw_rate_out = 16'(want_rate);
		r.want.steered = want_st;
		rows.insert(rows.size(), r);
	endfunction

	function automatic int rand_quat();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	// random word; mostly well-formed poses, some at or near the centre
	function automatic item_t rand_word();
		item_t w;
		int k, v;
		w.cmd_yaw_rate = 16'($urandom);
		k = $urandom_range(9);
		if (k == 0) begin
			w.robot_x = 32'(m_cx);
			w.robot_y = 32'(m_cy);
		end else if (k < 4) begin
			w.robot_x = 32'(m_cx + (int'($urandom_range(2000000)) - 1000000));
			w.robot_y = 32'(m_cy + (int'($urandom_range(2000000)) - 1000000));
		end else begin
			w.robot_x = 32'($urandom);
			w.robot_y = 32'($urandom);
		end
		k = $urandom_range(9);
		v = rand_quat();
		if (k == 0)
			{w.quat_x, w.quat_y, w.quat_z, w.quat_w} = '0;
		else if (k == 1) begin
			// pitch of +/-90 degrees
			w.quat_x = 16'(v); w.quat_z = 16'(v);
			w.quat_y = 16'(v); w.quat_w = 16'(-v);
		end else begin
			w.quat_x = 16'(rand_quat()); w.quat_y = 16'(rand_quat());
			w.quat_z = 16'(rand_quat()); w.quat_w = 16'(v);
		end
		w.pose_valid = ($urandom_range(7) != 0);
		return w;
	endfunction

	initial begin
		int cur_phase, g, mx;
		result_t none;
		none = '0;
		errors = 0;
		burst_left = 0;
		cur_fixed = 1'b0;
		cur_want = '0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		m_enable = 1'b0; m_cx = 0; m_cy = 0; m_gain = 6144; m_max = 2048;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase 0: reset registers, tracking off, everything passes through
		add_row(0, make_word(-32768, 0, 0, 0, 0, 0, 16384, 1), 1, -32768, 0);
		add_row(0, make_word(32767, -1, -1, 16384, 0, 0, 0, 1), 1, 32767, 0);
		add_row(0, make_word(0, 5, 5, 0, 0, 0, 0, 0), 1, 0, 0);
		// phase 1: tracking on, zero limit clamps to 0; invalid pose passes
		add_row(1, make_word(1234, 65536, 0, 0, 0, 0, 16384, 1), 1, 0, 1);
		add_row(1, make_word(-777, 65536, 0, 0, 0, 0, 16384, 0), 1, -777, 0);
		// phase 2: full gain and limit, checked by the model
		add_row(2, make_word(0, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 0, 0, 0, 11585, 0, 11585, 1), 0, 0, 0);
		add_row(2, make_word(0, 100 << 16, -(50 << 16), 0, 0, 0, 16384, 1), 0, 0, 0);
		add_row(2, make_word(0, 0, 0, 0, 0, 0, 16384, 1), 0, 0, 0);
		add_row(2, make_word(0, 200 << 16, -(50 << 16), 0, 0, 0, 16384, 1), 0, 0, 0);
		add_row(2, make_word(0, 200 << 16, -(50 << 16), 0, 0, 16384, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 200 << 16, -(50 << 16), 0, 0, -16384, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 32'h80000000, 32'h80000000, -16384, -16384,
			-16384, -16384, 1), 0, 0, 0);
		add_row(2, make_word(0, 32'h7fffffff, 32'h7fffffff, 16384, 16384,
			16384, 16384, 1), 0, 0, 0);
		add_row(2, make_word(0, 32'h80000000, 32'h7fffffff, 16384, 0, 0, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 100 << 16, 0, 0, 0, 1, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 100 << 16, 0, 0, 0, -1, 0, 1), 0, 0, 0);
		add_row(2, make_word(0, 99 << 16, -(50 << 16), 0, 0, 5793, 5793, 1), 0, 0, 0);

		cur_phase = 0;
		foreach (rows[i]) begin
			if (rows[i].phase != cur_phase) begin
				drain();
				cur_phase = rows[i].phase;
				if (cur_phase == 1) begin
					write_reg(REG_ENABLE, 32'd1);
					write_reg(REG_MAX_RATE, 32'd0);
				end else
					set_regs(1, 100 << 16, -(50 << 16), 32767, 32767);
			end
			send(rows[i].word, rows[i].fixed, rows[i].want);
		end

		// random phases, limits and gains at their extremes among them
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain();
			case (p % 4)
				0: begin g = 32767; mx = 32767; end
				1: begin g = 0; mx = $urandom_range(32767); end
				2: begin g = $urandom_range(32767); mx = 0; end
				default: begin g = $urandom_range(32767); mx = $urandom_range(32767); end
			endcase
			if (p == 3)
				set_regs(0, $urandom, $urandom, g, mx);
			else if (p % 2 == 0)
				set_regs(1, $urandom, $urandom, g, mx);
			else
				set_regs(1, int'($urandom_range(2000000)) - 1000000,
					int'($urandom_range(2000000)) - 1000000, g, mx);
			// writes to unused indexes must leave the registers alone
			write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send(rand_word(), 0, none);
		end

		drain();
		if (errors == 0)
			$display("heading_hold_to_orbit_center regression: pass");
		else
			$display("heading_hold_to_orbit_center regression: fail");
		$finish;
	end

endmodule
